// ===== hdl/c_subset_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer_defines.svh
// Assertion helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ctok_pkg.sv =====
// ----------------------------------------------------------------------------
// ctok_pkg
// Token codes, scan modes, token record and keyword spelling tables.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;

  // token kinds
  localparam logic [3:0] K_NUM    = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_INT    = 4'd2;
  localparam logic [3:0] K_RETURN = 4'd3;
  localparam logic [3:0] K_VOID   = 4'd4;
  localparam logic [3:0] K_EOF    = 4'd5;
  localparam logic [3:0] K_LPAREN = 4'd6;
  localparam logic [3:0] K_RPAREN = 4'd7;
  localparam logic [3:0] K_LBRACE = 4'd8;
  localparam logic [3:0] K_RBRACE = 4'd9;
  localparam logic [3:0] K_SEMI   = 4'd10;
  localparam logic [3:0] K_ERROR  = 4'd11;

  // scan modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  // keyword slots in the candidate mask
  localparam int unsigned KW_N = 3;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] len;
    logic [7:0] bad;
  } token_t;

  typedef struct packed {
    token_t     tok_a;   // first token (flushed one, or the only one)
    token_t     tok_b;   // second token when two are produced
    logic [1:0] cnt;     // tokens produced by this request, 0..2
  } lex_out_t;

  function automatic logic [7:0] kw_len(input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = 8'd3;
      2'd1:    r = 8'd6;
      2'd2:    r = 8'd4;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] k);
    logic [3:0] r;
    case (k)
      2'd0:    r = K_INT;
      2'd1:    r = K_RETURN;
      2'd2:    r = K_VOID;
      default: r = K_IDENT;
    endcase
    return r;
  endfunction

  // Character of keyword k at position pos; zero past the end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0:    r = "i";
          3'd1:    r = "n";
          3'd2:    r = "t";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    r = "r";
          3'd1:    r = "e";
          3'd2:    r = "t";
          3'd3:    r = "u";
          3'd4:    r = "r";
          3'd5:    r = "n";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    r = "v";
          3'd1:    r = "o";
          3'd2:    r = "i";
          3'd3:    r = "d";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ctok_lexer.sv =====
// ----------------------------------------------------------------------------
// ctok_lexer
// Scan state and the per-character decode: classifies one held character,
// forms up to two tokens and updates the state when the request retires.
// ----------------------------------------------------------------------------
module ctok_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = ctok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         char_byte,
  input  logic               end_of_input,
  input  logic               upd,      // request retires: commit next state
  output ctok_pkg::lex_out_t lex
);
  import ctok_pkg::*;
`include "c_subset_tokenizer_defines.svh"

  localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [KW_N-1:0] cand_r, cand_nxt;

  logic [1:0]    mode_eff;
  logic          is_digit, is_letter, is_space;
  logic          flush_v;
  token_t        flush_tok, own_tok;
  logic          own_v;
  logic [KW_N-1:0] cand_take, cand_start;
  logic [7:0]    len_inc;

  always_comb begin
    is_digit  = (char_byte >= "0") && (char_byte <= "9");
    is_letter = ((char_byte >= "a") && (char_byte <= "z")) ||
                ((char_byte >= "A") && (char_byte <= "Z"));
    is_space  = (char_byte == 8'h20) || (char_byte == 8'h09) ||
                (char_byte == 8'h0D) || (char_byte == 8'h0A);
    // unused mode code behaves as idle
    mode_eff  = ((mode_r == MODE_NUM) || (mode_r == MODE_IDENT)) ? mode_r : MODE_IDLE;
    len_inc   = (len_r < LEN_CAP) ? len_r + 8'd1 : len_r;
  end

  // keyword tracking: a candidate survives while the spelling still matches
  always_comb begin
    for (int k = 0; k < KW_N; k++) begin
      cand_take[k]  = cand_r[k] && (len_r < kw_len(2'(k))) &&
                      (kw_char(2'(k), len_r[2:0]) == char_byte);
      cand_start[k] = (kw_char(2'(k), 3'd0) == char_byte);
    end
  end

  // pending token as it would be flushed
  always_comb begin
    flush_v        = (mode_eff != MODE_IDLE);
    flush_tok.kind = (mode_eff == MODE_NUM) ? K_NUM : K_IDENT;
    flush_tok.len  = len_r;
    flush_tok.bad  = 8'h00;
    if (mode_eff == MODE_IDENT) begin
      for (int k = 0; k < KW_N; k++) begin
        if (cand_r[k] && (len_r == kw_len(2'(k)))) begin
          flush_tok.kind = kw_kind(2'(k));
        end
      end
    end
  end

  always_comb begin
    mode_nxt     = MODE_IDLE;
    len_nxt      = 8'd0;
    cand_nxt     = '0;
    own_v        = 1'b0;
    own_tok      = '0;
    lex          = '0;
    if (end_of_input) begin
      own_v        = 1'b1;
      own_tok.kind = K_EOF;
    end else if (is_digit) begin
      if (mode_eff == MODE_IDLE) begin
        mode_nxt = MODE_NUM;
        len_nxt  = 8'd1;
      end else begin
        mode_nxt = mode_eff;
        len_nxt  = len_inc;
        cand_nxt = cand_take;
      end
    end else if (is_letter) begin
      if (mode_eff == MODE_IDENT) begin
        mode_nxt = MODE_IDENT;
        len_nxt  = len_inc;
        cand_nxt = cand_take;
      end else begin
        mode_nxt = MODE_IDENT;
        len_nxt  = 8'd1;
        cand_nxt = cand_start;
      end
    end else if (!is_space) begin
      own_v       = 1'b1;
      own_tok.len = 8'd1;
      case (char_byte)
        "(":     own_tok.kind = K_LPAREN;
        ")":     own_tok.kind = K_RPAREN;
        "{":     own_tok.kind = K_LBRACE;
        "}":     own_tok.kind = K_RBRACE;
        ";":     own_tok.kind = K_SEMI;
        default: begin
          own_tok.kind = K_ERROR;
          own_tok.bad  = char_byte;
        end
      endcase
    end

    // a letter after a number, end of input, or any byte that is neither digit nor letter closes the pending run
    if (flush_v && (end_of_input || is_space || (!is_digit && !is_letter) ||
                    (is_letter && (mode_eff == MODE_NUM)))) begin
      lex.tok_a = flush_tok;
      lex.tok_b = own_tok;
      lex.cnt   = own_v ? 2'd2 : 2'd1;
    end else begin
      lex.tok_a = own_tok;
      lex.cnt   = own_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= 8'd0;
      cand_r <= '0;
    end else if (upd) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      cand_r <= cand_nxt;
    end
  end

  `CTOK_ASSERT_NOW(a_idle_clear, mode_r == MODE_IDLE, (len_r == 8'd0) && (cand_r == '0), "idle with leftover token state")
  `CTOK_ASSERT_NOW(a_num_nocand, mode_r == MODE_NUM, cand_r == '0, "number run carries keyword candidates")
  `CTOK_ASSERT_NOW(a_run_len, mode_r != MODE_IDLE, (len_r != 8'd0) && (len_r <= LEN_CAP), "pending run length out of range")

endmodule

// ===== hdl/ctok_out_reg.sv =====
// ----------------------------------------------------------------------------
// ctok_out_reg
// Result register: holds one token until the downstream side takes it.
// ----------------------------------------------------------------------------
module ctok_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ctok_pkg::token_t tok,
  input  logic             last,
  output logic             room,       // register free or drained this cycle
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [3:0]       out_tuser,  // [3:0] token_kind
  output logic [15:0]      out_tdata,  // [7:0] token_length, [15:8] bad_char
  output logic             out_tlast   // last_of_run
);
  import ctok_pkg::*;

  logic   vld_r;
  token_t tok_r;
  logic   last_r;

  assign room       = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tuser  = tok_r.kind;
  assign out_tdata  = {tok_r.bad, tok_r.len};
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (room) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      tok_r  <= tok;
      last_r <= last;
    end
  end

endmodule

// ===== hdl/c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Byte-serial tokenizer for a small C subset with a stream in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one character per request on in_tdata[7:0]; in_tlast high marks
//   end of input (character ignored), which flushes the pending token and
//   gives an EOF token. Output: one token per transfer, kind on out_tuser,
//   length and offending byte on out_tdata, out_tlast on the final token
//   caused by one input request. Whitespace gives no token of its own, and
//   bytes that only extend a run give none.
//   Path: a request is registered in the held-request register on acceptance,
//   and its first token is loaded into the output register once it has room.
//   Throughput: one input request per cycle while each gives at most one
//   token and the output register has room; a request that closes a run and
//   adds its own token (two tokens) holds the input register until its second
//   token is loaded, since the output register takes one token per cycle.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   scanner to idle with no pending token.
//   Stall: when out_tready is low the token stays in the output register, a
//   held request with a token to give waits, and in_tready drops once both are full.
// ----------------------------------------------------------------------------
module c_subset_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = ctok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic [15:0] out_tdata,  // [7:0] token_length, [15:8] bad_char
  output logic        out_tlast   // last_of_run
);
  import ctok_pkg::*;
`include "c_subset_tokenizer_defines.svh"

  // held request
  logic       item_v_r, item_v_nxt;
  logic [7:0] item_c_r;
  logic       item_eoi_r;
  // set after the first of two tokens has gone out
  logic       phase_r, phase_nxt;

  lex_out_t   lex;
  logic       room;
  logic       emit, retire, in_acc;
  token_t     emit_tok;
  logic       emit_last;

  ctok_lexer #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_byte    (item_c_r),
    .end_of_input (item_eoi_r),
    .upd          (retire),
    .lex          (lex)
  );

  // One token leaves per cycle when the output register has room. A request
  // retires once its last token is loaded, or at once if it gives none.
  always_comb begin
    emit      = item_v_r && room && (lex.cnt != 2'd0);
    retire    = item_v_r && ((lex.cnt == 2'd0) ||
                             (room && ((lex.cnt == 2'd1) || phase_r)));
    emit_tok  = phase_r ? lex.tok_b : lex.tok_a;
    emit_last = phase_r || (lex.cnt == 2'd1);
    in_tready = !item_v_r || retire;
    in_acc    = in_tvalid && in_tready;

    item_v_nxt = in_acc ? 1'b1 : (retire ? 1'b0 : item_v_r);

    phase_nxt = phase_r;
    if (retire) begin
      phase_nxt = 1'b0;
    end else if (emit && (lex.cnt == 2'd2)) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_c_r   <= in_tdata;
      item_eoi_r <= in_tlast;
    end
  end

  ctok_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .tok        (emit_tok),
    .last       (emit_last),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `CTOK_ASSERT_NOW(a_phase_held, phase_r, item_v_r && (lex.cnt == 2'd2), "second-token phase without a two-token request")
  `CTOK_ASSERT_NXT(a_split_hold, emit && !phase_r && (lex.cnt == 2'd2), phase_r && item_v_r && out_tvalid && !out_tlast, "first of two tokens not followed by a held request")
  `CTOK_ASSERT_NXT(a_final_last, emit && emit_last, out_tvalid && out_tlast, "final token of a request lost its last flag")

endmodule

// ===== tb/tb_c_subset_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_subset_tokenizer
// Self-checking bench for the byte-serial C subset tokenizer.
// ----------------------------------------------------------------------------
// Character requests come from a queue that the stimulus block fills: a short
// directed text first, then long runs that can reach length saturation, then
// random token streams with noise bytes and end marks. A shadow scanner
// predicts the tokens for each accepted request. The token side checks every
// accepted token field by field against the oldest prediction. Both sides
// idle or stall at random, with bursts where neither does.
// ----------------------------------------------------------------------------
module tb_c_subset_tokenizer;
  import ctok_pkg::*;

  localparam int unsigned LEN_CAP =
    (MAX_TOKEN_LEN_DEF < 255) ? MAX_TOKEN_LEN_DEF : 255;
  localparam int STIM_ITEMS   = 1850;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES = 20;    // tail after the last token, well over latency

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] len;
    logic [7:0] bad;
    logic       last;
  } token_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [3:0]  out_tuser;
  logic [15:0] out_tdata;
  logic        out_tlast;

  c_subset_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  char_req_t  char_q[$];            // character requests not yet driven
  token_rec_t expected_tokens[$];   // predicted tokens, oldest first
  int         errors = 0;

  // idle / stall control
  int in_gap = 0;
  bit in_idle_on = 1'b1;
  int out_hold = 0;
  bit out_idle_on = 1'b1;
  int quiet = 0;

  // shadow scanner state
  logic [1:0] scan_mode = MODE_IDLE;
  logic [7:0] run_len = 8'd0;
  logic [2:0] kw_alive = 3'b000;    // int, return, void still matching

  string      kw_word [3] = '{"int", "return", "void"};
  logic [3:0] kw_token [3] = '{K_INT, K_RETURN, K_VOID};
  string      near_kw [13] = '{"in", "intx", "int0", "retur", "returns", "vo",
                               "voidd", "Int", "RETURN", "i", "r", "v", "void9"};

  initial forever #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow scanner
  // --------------------------------------------------------------------------
  function automatic token_rec_t make_tok(logic [3:0] kind, logic [7:0] len,
                                          logic [7:0] bad);
    token_rec_t t;
    t = '0;
    t.kind = kind;
    t.len  = len;
    t.bad  = bad;
    return t;
  endfunction

  // Append one character to the pending run; keywords drop out on mismatch.
  function automatic void extend_run(logic [7:0] c);
    for (int k = 0; k < 3; k++)
      if (kw_alive[k] && (run_len >= kw_word[k].len() || kw_word[k][run_len] != c))
        kw_alive[k] = 1'b0;
    if (run_len < LEN_CAP)
      run_len = run_len + 8'd1;
  endfunction

  function automatic void open_run(logic [1:0] mode, logic [7:0] c);
    scan_mode = mode;
    run_len   = 8'd0;
    kw_alive  = (mode == MODE_IDENT) ? 3'b111 : 3'b000;
    extend_run(c);
  endfunction

  // Close the pending run, if any; returns 1 with its token.
  function automatic bit close_run(output token_rec_t t);
    t = make_tok(K_IDENT, run_len, 8'd0);
    if (scan_mode == MODE_NUM) begin
      t.kind = K_NUM;
    end else if (scan_mode == MODE_IDENT) begin
      for (int j = 0; j < 3; j++)
        if (kw_alive[j] && run_len == kw_word[j].len())
          t.kind = kw_token[j];
    end else begin
      scan_mode = MODE_IDLE;
      return 1'b0;
    end
    scan_mode = MODE_IDLE;
    run_len   = 8'd0;
    kw_alive  = 3'b000;
    return 1'b1;
  endfunction

  // Tokens caused by one accepted request, appended to expected_tokens.
  function automatic void lex_predict(logic [7:0] c, logic eoi);
    token_rec_t toks [2];
    token_rec_t t;
    int         n;
    bit         is_digit;
    bit         is_letter;
    bit         is_blank;
    n = 0;
    is_digit  = (c >= "0" && c <= "9");
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_blank  = (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF);
    if (eoi) begin
      if (close_run(t)) begin
        toks[n] = t;
        n++;
      end
      toks[n] = make_tok(K_EOF, 8'd0, 8'd0);
      n++;
    end else if (is_digit) begin
      // digits extend either kind of run
      if (scan_mode == MODE_IDLE)
        open_run(MODE_NUM, c);
      else
        extend_run(c);
    end else if (is_letter) begin
      if (scan_mode == MODE_IDENT) begin
        extend_run(c);
      end else begin
        // a letter ends a number and starts an identifier
        if (close_run(t)) begin
          toks[n] = t;
          n++;
        end
        open_run(MODE_IDENT, c);
      end
    end else begin
      if (close_run(t)) begin
        toks[n] = t;
        n++;
      end
      if (!is_blank) begin
        case (c)
          "(":     toks[n] = make_tok(K_LPAREN, 8'd1, 8'd0);
          ")":     toks[n] = make_tok(K_RPAREN, 8'd1, 8'd0);
          "{":     toks[n] = make_tok(K_LBRACE, 8'd1, 8'd0);
          "}":     toks[n] = make_tok(K_RBRACE, 8'd1, 8'd0);
          ";":     toks[n] = make_tok(K_SEMI, 8'd1, 8'd0);
          default: toks[n] = make_tok(K_ERROR, 8'd1, c);
        endcase
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      t = toks[i];
      t.last = (i == n - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_char(logic [7:0] c);
    char_req_t r;
    r.ch  = c;
    r.eoi = 1'b0;
    char_q.push_back(r);
  endfunction

  // End mark; the character lane carries a random byte that must be ignored.
  function automatic void push_eoi();
    char_req_t r;
    r.ch  = 8'($urandom_range(0, 255));
    r.eoi = 1'b1;
    char_q.push_back(r);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Identifier body after the first letter: letters and digits.
  function automatic void push_ident_tail(int n);
    for (int i = 0; i < n; i++)
      push_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
  endfunction

  function automatic void push_long_run(bit digits);
    int n;
    n = $urandom_range(250, 300);
    if (digits) begin
      for (int i = 0; i < n; i++)
        push_char(rand_digit());
    end else begin
      // starts like a keyword so the candidate mask has to drop out late
      push_text("return");
      push_ident_tail(n - 6);
    end
  endfunction

  // One random lexeme, sometimes glued to the next one with no separator.
  function automatic void push_lexeme();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_text(kw_word[$urandom_range(0, 2)]);
    end else if (r < 25) begin
      push_text(near_kw[$urandom_range(0, 12)]);
    end else if (r < 44) begin
      push_char(rand_letter());
      push_ident_tail($urandom_range(0, 7));
    end else if (r < 59) begin
      for (int i = $urandom_range(1, 6); i > 0; i--)
        push_char(rand_digit());
    end else if (r < 74) begin
      case ($urandom_range(0, 4))
        0:       push_char("(");
        1:       push_char(")");
        2:       push_char("{");
        3:       push_char("}");
        default: push_char(";");
      endcase
    end else if (r < 84) begin
      for (int i = $urandom_range(1, 3); i > 0; i--)
        push_char(rand_blank());
    end else if (r < 96) begin
      push_char(8'($urandom_range(0, 255)));
    end else if (r < 99) begin
      push_eoi();
    end else begin
      push_long_run(1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1) == 0)
      push_char(rand_blank());
  endfunction

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap(bit on);
    int r;
    if (!on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: one character request per handshake, random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : char_driver
    char_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        lex_predict(in_tdata, in_tlast);
      // free to move on when nothing is held or the held request just went
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (char_q.size() > 0) begin
          r = char_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= r.ch;
          in_tlast  <= r.eoi;
          in_gap    <= pick_gap(in_idle_on);
          if ($urandom_range(0, 199) == 0)
            in_idle_on <= !in_idle_on;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token checker with random back-pressure
  // --------------------------------------------------------------------------
  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%t: token %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : token_check
    token_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $display("%t: unexpected token, expected none, got kind %0d len %0d bad %0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[15:8]);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_tuser));
          check_field("length", want.len, out_tdata[7:0]);
          check_field("bad_char", want.bad, out_tdata[15:8]);
          check_field("last", 8'(want.last), 8'(out_tlast));
        end
      end
      if (out_hold > 0) begin
        out_hold   <= out_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          out_hold <= pick_gap(out_idle_on);
      end
      if ($urandom_range(0, 299) == 0)
        out_idle_on <= !out_idle_on;
    end
  end

  // Watchdog: ends the run when neither a request nor a token moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%t: timeout, %0d tokens still expected", $time, expected_tokens.size());
      $display("** c_subset_tokenizer: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    // directed: all keywords, every punctuation mark, digit inside an
    // identifier, letter right after a number, tab, CR and LF blanks, invalid
    // bytes at both ends of the range, end mark with a pending run, and a
    // repeated end mark
    push_text("int(void){return");
    push_char(CH_TAB);
    push_text("7x9;}");
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_CR);
    push_char(CH_LF);
    push_char("q");
    push_eoi();
    push_eoi();

    // long runs on both run kinds, which can reach length saturation
    push_long_run(1'b1);
    push_char(";");
    push_long_run(1'b0);
    push_char(" ");

    while (char_q.size() < STIM_ITEMS)
      push_lexeme();
    push_eoi();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_tvalid)
      @(posedge clk);
    while (expected_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** c_subset_tokenizer: PASSED **");
    end else begin
      $display("** c_subset_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
